// ===== sv/bqf_pkg.sv =====
// Shared types, constants and saturation helpers for the multichannel biquad filter.
package bqf_pkg;

    localparam int CHAN_W      = 5;
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 32;
    localparam int HIST_Y_W    = 32;
    localparam int COEF_FRAC   = 28;
    localparam int PROD_W      = 64;
    localparam int ACC_W       = 67;
    localparam int Y_W         = ACC_W - COEF_FRAC;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    // coefficient register indexes
    localparam logic [IDX_W-1:0] REG_B0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_B1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_B2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_A1 = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_A2 = IDX_W'(4);

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    typedef struct packed {
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } bqf_coef_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic                in_range;
    } bqf_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x1;
        logic [SAMPLE_W-1:0] x2;
        logic [HIST_Y_W-1:0] y1;
        logic [HIST_Y_W-1:0] y2;
    } bqf_hist_t;

    function automatic logic [HIST_Y_W-1:0] sat_hist(input logic [Y_W-1:0] y);
        logic [Y_W-HIST_Y_W:0] top;
        top = y[Y_W-1:HIST_Y_W-1];
        if (&top || ~|top) begin
            return y[HIST_Y_W-1:0];
        end else if (y[Y_W-1]) begin
            return {1'b1, {(HIST_Y_W-1){1'b0}}};
        end else begin
            return {1'b0, {(HIST_Y_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat_out(input logic [Y_W-1:0] y);
        logic [Y_W-SAMPLE_W:0] top;
        top = y[Y_W-1:SAMPLE_W-1];
        if (&top || ~|top) begin
            return y[SAMPLE_W-1:0];
        end else if (y[Y_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== sv/multichannel_biquad_iir_filter.sv =====
// Top level of the multichannel direct form I biquad filter with coefficient registers.
//
// Usage:
//  - s_ channel: one transfer per sample, carrying s_channel and s_sample_in (Q1.23).
//  - m_ channel: one transfer per input, m_channel_out echoes the channel and
//    m_sample_out is the filtered Q1.23 sample, saturated to 24 bits.
//  - cfg_ channel: cfg_index picks b0, b1, b2, a1, a2 (s3.28); other indexes are
//    dropped. cfg_ready is always high. Write only while the filter is idle.
//  - Channels at or above CHANNELS return zero and leave all history untouched.
// Timing:
//  - A two-entry queue sits in front of the datapath, so s_ready stays high
//    until two samples wait behind the one the datapath is working on.
//  - In-range samples pass through the datapath in order: one history fetch,
//    five multiplies through a single 32x32 multiplier, one trailing
//    accumulate, one round/saturate/write-back step. Out-of-range samples
//    skip the history fetch and the multiplies.
//  - If m_ready stays low, the datapath holds its finished result and the
//    queue fills; s_ready then drops.
// Reset: coefficients return to b0 = 1.0 and the rest 0; all channel history
// reads as zero right away (per-channel valid bits, no clearing pass).
module multichannel_biquad_iir_filter #(
    parameter int CHANNELS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bqf_pkg::CHAN_W-1:0]   s_channel,
    input  logic [bqf_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bqf_pkg::CHAN_W-1:0]   m_channel_out,
    output logic [bqf_pkg::SAMPLE_W-1:0] m_sample_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bqf_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bqf_pkg::COEF_W-1:0]   cfg_data
);
    import bqf_pkg::*;

    bqf_coef_t  coef_reg;
    logic       q_valid;
    logic       q_pop;
    bqf_item_t  q_item;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= COEF_ONE;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_B0:  coef_reg.b0 <= cfg_data;
                REG_B1:  coef_reg.b1 <= cfg_data;
                REG_B2:  coef_reg.b2 <= cfg_data;
                REG_A1:  coef_reg.a1 <= cfg_data;
                REG_A2:  coef_reg.a2 <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // front: accepts samples, flags range, queues
    bqf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_channel   (s_channel),
        .s_sample_in (s_sample_in),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // back: history fetch, MAC sequence, rounding, output register
    bqf_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .coef          (coef_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_sample_out  (m_sample_out)
    );

endmodule

// ===== sv/bqf_front.sv =====
// Input side: takes sample transfers, tags channel range, and queues them for the datapath.
module bqf_front #(
    parameter int CHANNELS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bqf_pkg::CHAN_W-1:0]   s_channel,
    input  logic [bqf_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                      q_valid,
    output bqf_pkg::bqf_item_t        q_item,
    input  logic                      q_pop
);
    import bqf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bqf_item_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    bqf_item_t          in_item;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        in_item.channel  = s_channel;
        in_item.sample   = s_sample_in;
        in_item.in_range = (32'(s_channel) < CHANNELS);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

// ===== sv/bqf_back.sv =====
// Datapath: per-channel history memory, sequential multiply-accumulate, rounding and output register.
module bqf_back #(
    parameter int CHANNELS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  bqf_pkg::bqf_item_t        q_item,
    output logic                      q_pop,
    input  bqf_pkg::bqf_coef_t        coef,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bqf_pkg::CHAN_W-1:0]   m_channel_out,
    output logic [bqf_pkg::SAMPLE_W-1:0] m_sample_out
);
    import bqf_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [2:0] LAST_MUL  = 3'd4;
    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [2:0] FIRST_SUB = 3'd3;

    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC - 1);

    bqf_hist_t              hist_mem [CHANNELS];
    logic [CHANNELS-1:0]    hvalid_reg;
    bqf_hist_t              hist_reg;

    logic [1:0]             state_reg;
    logic [2:0]             step_reg;
    bqf_item_t              item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   sub_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                   m_valid_reg;
    logic [CHAN_W-1:0]      m_channel_reg;
    logic [SAMPLE_W-1:0]    m_sample_reg;

    logic signed [COEF_W-1:0] mul_coef;
    logic signed [COEF_W-1:0] mul_data;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]       acc_rnd;
    logic [Y_W-1:0]         y_val;
    logic                   fin_go;
    logic                   hist_we;
    logic [CH_W-1:0]        rd_addr;
    logic [CH_W-1:0]        wr_addr;
    bqf_hist_t              hist_wr;

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign fin_go  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign hist_we = fin_go && item_reg.in_range;
    assign rd_addr = CH_W'(q_item.channel);
    assign wr_addr = CH_W'(item_reg.channel);

    // operand select: feedforward taps first, feedback taps subtract
    always_comb begin
        unique case (step_reg)
            3'd0: begin
                mul_coef = coef.b0;
                mul_data = {{(COEF_W-SAMPLE_W){item_reg.sample[SAMPLE_W-1]}}, item_reg.sample};
            end
            3'd1: begin
                mul_coef = coef.b1;
                mul_data = {{(COEF_W-SAMPLE_W){hist_reg.x1[SAMPLE_W-1]}}, hist_reg.x1};
            end
            3'd2: begin
                mul_coef = coef.b2;
                mul_data = {{(COEF_W-SAMPLE_W){hist_reg.x2[SAMPLE_W-1]}}, hist_reg.x2};
            end
            3'd3: begin
                mul_coef = coef.a1;
                mul_data = hist_reg.y1;
            end
            3'd4: begin
                mul_coef = coef.a2;
                mul_data = hist_reg.y2;
            end
            default: begin
                mul_coef = '0;
                mul_data = '0;
            end
        endcase
    end

    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        // round half up, then floor by the coefficient scale
        acc_rnd  = acc_reg + HALF_LSB;
        y_val    = acc_rnd[ACC_W-1:COEF_FRAC];
        hist_wr.x1 = item_reg.sample;
        hist_wr.x2 = hist_reg.x1;
        hist_wr.y1 = sat_hist(y_val);
        hist_wr.y2 = hist_reg.y1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            hvalid_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        step_reg  <= '0;
                        state_reg <= q_item.in_range ? ST_MAC : ST_FIN;
                    end
                end
                ST_MAC: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (hist_we) begin
                hvalid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
            acc_reg  <= '0;
        end
        if (state_reg == ST_MAC) begin
            if (step_reg <= LAST_MUL) begin
                prod_reg <= mul_coef * mul_data;
                sub_reg  <= (step_reg >= FIRST_SUB);
            end
            if (step_reg != '0) begin
                acc_reg <= acc_next;
            end
        end
        if (fin_go) begin
            m_channel_reg <= item_reg.channel;
            m_sample_reg  <= item_reg.in_range ? sat_out(y_val) : '0;
        end
    end

    // history memory: one read at pop, one write at finish
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.in_range) begin
            hist_reg <= hvalid_reg[rd_addr] ? hist_mem[rd_addr] : '0;
        end
        if (hist_we) begin
            hist_mem[wr_addr] <= hist_wr;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_reg;
    assign m_sample_out  = m_sample_reg;

    a_we_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> item_reg.in_range)
        else $error("history write for out-of-range channel");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && !item_reg.in_range) |=> (m_sample_reg == '0))
        else $error("out-of-range channel produced nonzero sample");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (step_reg <= LAST_STEP))
        else $error("mac step overran");

endmodule
